// ===== hw/rtl/mss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mss_pkg
// Shared constants, types and reset values for the multirate sample scheduler.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int HW_SLOTS     = 4;
  localparam int SLOTS        = 4;
  localparam int ACTIVE_SLOTS = (SLOTS > HW_SLOTS) ? HW_SLOTS : SLOTS;

  localparam int SLOT_W     = 2;
  localparam int INTERVAL_W = 16;
  localparam int CHANNEL_W  = 4;
  localparam logic [CHANNEL_W-1:0] CHANNEL_MASK = 4'hf;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_BASE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_BASE  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END           = 8'd8;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef logic [HW_SLOTS-1:0]                 mask_t;
  typedef logic [HW_SLOTS-1:0][INTERVAL_W-1:0] interval_arr_t;
  typedef logic [HW_SLOTS-1:0][CHANNEL_W-1:0]  channel_arr_t;

  // Head of the due-mask queue as seen by the back end
  typedef struct packed {
    logic  valid;
    mask_t mask;
  } q_head_t;

  localparam interval_arr_t RESET_INTERVAL = {16'd1000, 16'd1000, 16'd100, 16'd2000};
  localparam channel_arr_t  RESET_CHANNEL  = {4'd7, 4'd6, 4'd5, 4'd1};

endpackage
`default_nettype wire

// ===== hw/rtl/multirate_sample_scheduler_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multirate_sample_scheduler_core
// Periodic conversion scheduler for four sensor slots.
// ----------------------------------------------------------------------------
// Each accepted item with in_tick set counts every slot down by one millisecond;
// the slots that fall due give one result each, in ascending slot order, the
// last one marked by last_due. A tick is taken whenever in_full is low, and
// in_full rises only when two ticks' due masks are still waiting. Results leave
// at one per cycle while the receiver pops, from a single output register, so
// a tick with k due slots gives k results (four at most). All counters start at
// zero, so every slot falls due on the first tick. The config port is always
// ready; new intervals take effect at each slot's next reload.
// ----------------------------------------------------------------------------
module multirate_sample_scheduler_core
  import mss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic                  in_tick,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic [CHANNEL_W-1:0]       out_sel_channel,
  output logic [SLOT_W-1:0]          out_slot_index,
  output logic                       out_last_due,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  interval_arr_t interval;
  channel_arr_t  channel;
  logic    q_push, q_pop, q_full;
  mask_t   q_mask;
  q_head_t q_head;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  mss_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .interval (interval),
    .channel  (channel)
  );

  mss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_push && !in_full),
    .tick     (in_tick),
    .interval (interval),
    .q_push   (q_push),
    .q_mask   (q_mask)
  );

  mss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_mask (q_mask),
    .pop       (q_pop),
    .full      (q_full),
    .head      (q_head)
  );

  mss_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .q_pop           (q_pop),
    .channel         (channel),
    .out_pop         (out_pop && !out_empty),
    .out_empty       (out_empty),
    .out_sel_channel (out_sel_channel),
    .out_slot_index  (out_slot_index),
    .out_last_due    (out_last_due)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/mss_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mss_cfg
// Interval and channel registers per slot, written through the config port.
// ----------------------------------------------------------------------------
module mss_cfg
  import mss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output interval_arr_t              interval,
  output channel_arr_t               channel
);

  interval_arr_t interval_r, interval_nxt;
  channel_arr_t  channel_r, channel_nxt;
  logic [CFG_IDX_W-1:0] chan_off;

  assign chan_off = wr_index - REG_CHANNEL_BASE;

  always_comb begin
    interval_nxt = interval_r;
    channel_nxt  = channel_r;
    // drop writes beyond the register list
    if (wr_en) begin
      if (wr_index < REG_CHANNEL_BASE) begin
        interval_nxt[wr_index[SLOT_W-1:0]] = wr_data[INTERVAL_W-1:0];
      end else if (wr_index < REG_END) begin
        channel_nxt[chan_off[SLOT_W-1:0]] = wr_data[CHANNEL_W-1:0] & CHANNEL_MASK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= RESET_INTERVAL;
      channel_r  <= RESET_CHANNEL;
    end else begin
      interval_r <= interval_nxt;
      channel_r  <= channel_nxt;
    end
  end

  assign interval = interval_r;
  assign channel  = channel_r;

endmodule
`default_nettype wire

// ===== hw/rtl/mss_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mss_front
// Per-slot countdown counters; classifies each tick into a mask of due slots.
// ----------------------------------------------------------------------------
module mss_front
  import mss_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   accept,
  input  wire logic   tick,
  input  wire interval_arr_t interval,
  output logic        q_push,
  output mask_t       q_mask
);

  logic [HW_SLOTS-1:0][INTERVAL_W-1:0] remaining_r, remaining_nxt;
  logic [HW_SLOTS-1:0][INTERVAL_W-1:0] dec;
  mask_t due;

  always_comb begin
    remaining_nxt = remaining_r;
    dec           = '0;
    due           = '0;
    for (int i = 0; i < HW_SLOTS; i++) begin
      if (i < ACTIVE_SLOTS) begin
        // saturate at zero, then reload on reaching it
        dec[i] = (remaining_r[i] != '0) ? remaining_r[i] - 16'd1 : '0;
        due[i] = (dec[i] == '0);
        if (accept && tick) begin
          remaining_nxt[i] = due[i] ? interval[i] : dec[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
    end else begin
      remaining_r <= remaining_nxt;
    end
  end

  assign q_push = accept && tick && (due != '0);
  assign q_mask = due;

endmodule
`default_nettype wire

// ===== hw/rtl/mss_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mss_queue
// Short queue of due masks between the front and back ends.
// ----------------------------------------------------------------------------
module mss_queue
  import mss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire mask_t push_mask,
  input  wire logic pop,
  output logic      full,
  output q_head_t   head
);

  mask_t mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_mask;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.mask  = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

// ===== hw/rtl/mss_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mss_back
// Walks each due mask in slot order and hands one result a cycle to the
// output register whenever that register is free.
// ----------------------------------------------------------------------------
module mss_back
  import mss_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire q_head_t head,
  output logic        q_pop,
  input  wire channel_arr_t channel,
  input  wire logic   out_pop,
  output logic        out_empty,
  output logic [CHANNEL_W-1:0] out_sel_channel,
  output logic [SLOT_W-1:0]    out_slot_index,
  output logic                 out_last_due
);

  mask_t cur_mask_r, cur_mask_nxt;
  mask_t pick, rest;
  logic [SLOT_W-1:0] pick_idx;
  logic out_valid_r, out_valid_nxt;
  logic [CHANNEL_W-1:0] sel_channel_r;
  logic [SLOT_W-1:0]    slot_index_r;
  logic                 last_due_r;
  logic out_free, emit;

  // lowest set bit first
  always_comb begin
    pick     = '0;
    pick_idx = '0;
    for (int i = HW_SLOTS - 1; i >= 0; i--) begin
      if (cur_mask_r[i]) begin
        pick     = '0;
        pick[i]  = 1'b1;
        pick_idx = SLOT_W'(i);
      end
    end
  end

  assign rest     = cur_mask_r & ~pick;
  assign out_free = !out_valid_r || out_pop;
  assign emit     = out_free && (cur_mask_r != '0);
  assign q_pop    = head.valid && ((cur_mask_r == '0) || (emit && (rest == '0)));

  always_comb begin
    cur_mask_nxt  = cur_mask_r;
    out_valid_nxt = out_valid_r;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      cur_mask_nxt  = rest;
      out_valid_nxt = 1'b1;
    end
    if (q_pop) begin
      cur_mask_nxt = head.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_mask_r  <= cur_mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sel_channel_r <= channel[pick_idx] & CHANNEL_MASK;
      slot_index_r  <= pick_idx;
      last_due_r    <= (rest == '0);
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_sel_channel = sel_channel_r;
  assign out_slot_index  = slot_index_r;
  assign out_last_due    = last_due_r;

endmodule
`default_nettype wire

// ===== hw/rtl/mss_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mss_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mss_checker
  import mss_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_full,
  input wire logic                  out_empty,
  input wire logic                  out_pop,
  input wire logic [CHANNEL_W-1:0]  out_sel_channel,
  input wire logic [SLOT_W-1:0]     out_slot_index,
  input wire logic                  out_last_due
);

  // after reset nothing waits and there is room for a tick
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("scheduler not idle after reset");

  // an item not yet taken holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_sel_channel)
      && $stable(out_slot_index) && $stable(out_last_due))
    else $error("waiting item changed before pop");

  // within one tick the next item follows at once with a higher slot
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop && !out_last_due |=>
      !out_empty && (out_slot_index > $past(out_slot_index)))
    else $error("due items out of slot order or gap within a tick");

  // slot three is always the final one of its tick
  a_top_slot_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_slot_index == SLOT_W'(HW_SLOTS - 1)) |-> out_last_due)
    else $error("highest slot not marked last");

endmodule

bind multirate_sample_scheduler_core mss_checker u_mss_checker (.*);
`default_nettype wire

// ===== tb/multirate_sample_scheduler_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multirate_sample_scheduler_core_tb
// Self-checking bench for the four-slot periodic conversion scheduler.
// ----------------------------------------------------------------------------
// Tick items are pushed in bursts with random gaps, and results are popped on
// a rotating stall pattern. A model of the per-slot countdowns works out the
// due results of every accepted tick, and each popped result is checked
// against the oldest one. Slot periods and channel numbers are reprogrammed
// between phases, once the scheduler has gone quiet.
// ----------------------------------------------------------------------------
module multirate_sample_scheduler_core_tb;
  import mss_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_TICKS  = 230;
  localparam int PHASES        = 6;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP = '1;

  typedef struct packed {
    logic [CHANNEL_W-1:0] sel_channel;
    logic [SLOT_W-1:0]    slot_index;
    logic                 last_due;
  } due_result_t;

  // Per-slot countdowns and the due results still to be popped
  class due_slot_board;
    logic [INTERVAL_W-1:0] interval_ms [HW_SLOTS];
    logic [CHANNEL_W-1:0]  channel [HW_SLOTS];
    logic [INTERVAL_W-1:0] remaining_ms [HW_SLOTS];
    due_result_t           pending_dues [$];
    int unsigned           errors;

    function new();
      for (int i = 0; i < HW_SLOTS; i++) begin
        interval_ms[i]  = RESET_INTERVAL[i];
        channel[i]      = RESET_CHANNEL[i];
        remaining_ms[i] = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < REG_CHANNEL_BASE) begin
        interval_ms[int'(idx - REG_INTERVAL_BASE)] = data;
      end else if (idx < REG_END) begin
        channel[int'(idx - REG_CHANNEL_BASE)] = data[CHANNEL_W-1:0] & CHANNEL_MASK;
      end
    endfunction

    function void take_tick(logic tick);
      logic [HW_SLOTS-1:0] due;
      due_result_t         r;
      if (!tick) return;
      due = '0;
      for (int i = 0; i < ACTIVE_SLOTS; i++) begin
        if (remaining_ms[i] != '0) remaining_ms[i] = remaining_ms[i] - 1'b1;
        if (remaining_ms[i] == '0) begin
          remaining_ms[i] = interval_ms[i];
          due[i] = 1'b1;
        end
      end
      for (int i = 0; i < ACTIVE_SLOTS; i++) begin
        if (due[i]) begin
          r.sel_channel = channel[i];
          r.slot_index  = SLOT_W'(i);
          // mark the highest due slot
          r.last_due    = ((due >> (i + 1)) == '0);
          pending_dues.push_back(r);
        end
      end
    endfunction

    function void check_due(logic [CHANNEL_W-1:0] sel, logic [SLOT_W-1:0] slot,
                            logic last);
      due_result_t want;
      if (pending_dues.size() == 0) begin
        $error("unexpected result: sel_channel %0d slot_index %0d last_due %0b",
               sel, slot, last);
        errors++;
        return;
      end
      want = pending_dues.pop_front();
      if (sel !== want.sel_channel) begin
        $error("sel_channel: expected %0d, got %0d", want.sel_channel, sel);
        errors++;
      end
      if (slot !== want.slot_index) begin
        $error("slot_index: expected %0d, got %0d", want.slot_index, slot);
        errors++;
      end
      if (last !== want.last_due) begin
        $error("last_due: expected %0b, got %0b", want.last_due, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic                  in_tick;
  logic                  out_empty;
  logic                  out_pop;
  logic [CHANNEL_W-1:0]  out_sel_channel;
  logic [SLOT_W-1:0]     out_slot_index;
  logic                  out_last_due;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [31:0]   cycles = '0;
  logic [1:0]    rx_mode;
  int unsigned   burst_left;
  due_slot_board board;

  multirate_sample_scheduler_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_tick         (in_tick),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_sel_channel (out_sel_channel),
    .out_slot_index  (out_slot_index),
    .out_last_due    (out_last_due),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("multirate_sample_scheduler_core regression: fail");
      $finish;
    end
  end

  // Receiver: rotate between free flow, light, heavy and long stalls
  assign rx_mode = cycles[7:6];

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        board.check_due(out_sel_channel, out_slot_index, out_last_due);
      end
      case (rx_mode)
        2'd0: out_pop <= 1'b1;
        2'd1: out_pop <= ($urandom_range(0, 1) == 0);
        2'd2: out_pop <= ($urandom_range(0, 3) == 0);
        default: out_pop <= (cycles[2:0] == 3'd0);
      endcase
    end
  end

  task automatic push_tick(input logic tick);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      // leave some bursts back to back
      if ($urandom_range(0, 3) != 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    burst_left--;
    in_push <= 1'b1;
    in_tick <= tick;
    @(posedge clk);
    while (in_full) @(posedge clk);
    board.take_tick(tick);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Hold until every due result has been popped, then let the back end settle
  task automatic drain();
    in_push <= 1'b0;
    while (board.pending_dues.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_interval();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r <= 10) return CFG_DATA_W'($urandom_range(1, 4));
    return CFG_DATA_W'($urandom_range(5, 24));
  endfunction

  task automatic random_phase(input int n_ticks, input bit huge_interval);
    int unsigned k;
    repeat ($urandom_range(1, 8)) begin
      k = $urandom_range(0, 9);
      if (k < HW_SLOTS) begin
        write_reg(REG_INTERVAL_BASE + CFG_IDX_W'(k), pick_interval());
      end else if (k < 2 * HW_SLOTS) begin
        write_reg(REG_CHANNEL_BASE + CFG_IDX_W'(k - HW_SLOTS), CFG_DATA_W'($urandom));
      end else begin
        write_reg(REG_END + CFG_IDX_W'($urandom_range(0, 247)), CFG_DATA_W'($urandom));
      end
    end
    if (huge_interval) begin
      write_reg(REG_INTERVAL_BASE + CFG_IDX_W'($urandom_range(0, HW_SLOTS - 1)), '1);
    end
    cfg_valid <= 1'b0;
    repeat (n_ticks) push_tick($urandom_range(0, 7) != 0);
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_tick    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    burst_left = 0;
    board      = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero, one and short periods; slot one keeps its reset period.
    // Out-of-range indexes must be ignored.
    write_reg(REG_INTERVAL_BASE, 16'h0000);
    write_reg(REG_INTERVAL_BASE + CFG_IDX_W'(2), 16'h0001);
    write_reg(REG_INTERVAL_BASE + CFG_IDX_W'(3), 16'h0003);
    write_reg(REG_END, 16'hffff);
    write_reg(REG_IDX_TOP, 16'hffff);
    cfg_valid <= 1'b0;
    // first tick: every slot due on the reset channels
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);
    repeat (6) push_tick(1'b1);
    drain();

    // Channel extremes, most with the upper data bits set; running counters keep going
    write_reg(REG_CHANNEL_BASE, 16'hfff0);
    write_reg(REG_CHANNEL_BASE + CFG_IDX_W'(1), 16'h000f);
    write_reg(REG_CHANNEL_BASE + CFG_IDX_W'(2), 16'h5a5a);
    write_reg(REG_CHANNEL_BASE + CFG_IDX_W'(3), 16'ha5a5);
    write_reg(REG_INTERVAL_BASE + CFG_IDX_W'(1), 16'h0002);
    write_reg(REG_INTERVAL_BASE + CFG_IDX_W'(2), 16'h0002);
    write_reg(REG_INTERVAL_BASE + CFG_IDX_W'(3), 16'h0001);
    cfg_valid <= 1'b0;
    repeat (6) push_tick(1'b1);
    push_tick(1'b0);
    repeat (2) push_tick(1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      random_phase(RANDOM_TICKS / PHASES, p == PHASES - 1);
    end

    if (board.errors == 0) begin
      $display("multirate_sample_scheduler_core regression: pass");
    end else begin
      $display("multirate_sample_scheduler_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
